// ===== sv/assert_macros.svh =====
// Assertion helpers used by the RTL top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Check that prop holds at every rising clock edge outside reset.
`define RRWA_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check that cond never holds outside reset.
`define RRWA_NEVER(lbl, clk, rst_n, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define RRWA_ASSERT(lbl, clk, rst_n, prop, msg)
`define RRWA_NEVER(lbl, clk, rst_n, cond, msg)
`endif
`endif

// ===== sv/rrwa_pkg.sv =====
`default_nettype none

package rrwa_pkg;

	localparam int ANGLE_BITS  = 12;
	localparam int COORD_BITS  = 12;

	localparam int RADIUS_BITS = 11;
	localparam int RING_BITS   = 10;
	localparam int RAD_BITS    = 12;
	localparam int PHASE_BITS  = 32;
	localparam int TRIG_BITS   = 17;
	localparam int OFF_BITS    = 10;
	localparam int SRAD_BITS   = 14;
	localparam int POS_BITS    = 18;

	localparam int CTR_BITS    = 12;
	localparam int AMP_BITS    = 8;
	localparam int LEN_BITS    = 10;
	localparam int SCR_BITS    = 13;
	localparam int WDATA_BITS  = 13;
	localparam int IDX_BITS    = 3;

	localparam logic [IDX_BITS-1:0] REG_CENTER_X      = 3'd0;
	localparam logic [IDX_BITS-1:0] REG_CENTER_Y      = 3'd1;
	localparam logic [IDX_BITS-1:0] REG_AMPLITUDE     = 3'd2;
	localparam logic [IDX_BITS-1:0] REG_WAVE_LENGTH   = 3'd3;
	localparam logic [IDX_BITS-1:0] REG_SCREEN_WIDTH  = 3'd4;
	localparam logic [IDX_BITS-1:0] REG_SCREEN_HEIGHT = 3'd5;

	localparam logic [SCR_BITS-1:0] RST_SCREEN_WIDTH  = 13'd640;
	localparam logic [SCR_BITS-1:0] RST_SCREEN_HEIGHT = 13'd480;

	// ring phase divider: dividend is ring << DIV_SHIFT, DIV_STEPS quotient bits per stage
	localparam int DIV_SHIFT  = 31;
	localparam int DIV_STEPS  = 4;
	localparam int DIV_STAGES = (RING_BITS + DIV_SHIFT + DIV_STEPS - 1) / DIV_STEPS;
	localparam int DIV_W      = DIV_STEPS * DIV_STAGES;

	localparam int TRIG_LAT  = 8;
	localparam int WARP_LAT  = 4;
	localparam int TOTAL_LAT = 1 + DIV_STAGES + TRIG_LAT + WARP_LAT;

	localparam logic signed [31:0] C1 = 32'sd1686629713;
	localparam logic signed [31:0] C3 = -32'sd693598668;
	localparam logic signed [31:0] C5 = 32'sd85569306;
	localparam logic signed [31:0] C7 = -32'sd5026995;
	localparam logic signed [31:0] C9 = 32'sd172272;
	localparam logic signed [31:0] Q30_ONE = 32'sd1073741824;
	localparam logic signed [47:0] TRIG_ONE = 48'sd32768;

	typedef struct packed {
		logic [RADIUS_BITS-1:0] base_radius;
		logic [RING_BITS-1:0]   ring_index;
		logic [ANGLE_BITS-1:0]  angle_code;
	} item_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] src_x;
		logic [COORD_BITS-1:0] src_y;
		logic                  src_ok;
		logic [COORD_BITS-1:0] dst_x;
		logic [COORD_BITS-1:0] dst_y;
		logic                  dst_ok;
	} result_t;

	typedef struct packed {
		logic [CTR_BITS-1:0] center_x;
		logic [CTR_BITS-1:0] center_y;
		logic [AMP_BITS-1:0] amplitude;
		logic [LEN_BITS-1:0] wave_length;
		logic [SCR_BITS-1:0] screen_width;
		logic [SCR_BITS-1:0] screen_height;
	} cfg_t;

	// divide by 2^30, rounding toward zero
	function automatic logic signed [63:0] trunc_q30(logic signed [63:0] v);
		logic signed [63:0] bias;
		bias = v[63] ? 64'sd1073741823 : 64'sd0;
		return (v + bias) >>> 30;
	endfunction

	// divide by 2^15, rounding toward zero
	function automatic logic signed [47:0] trunc_q15(logic signed [47:0] v);
		logic signed [47:0] bias;
		bias = v[47] ? 48'sd32767 : 48'sd0;
		return (v + bias) >>> 15;
	endfunction

	function automatic logic signed [31:0] mul_q30(logic signed [31:0] a,
		logic signed [31:0] b);
		logic signed [63:0] p;
		logic signed [63:0] q;
		p = a * b;
		q = trunc_q30(p);
		return q[31:0];
	endfunction

endpackage

`default_nettype wire

// ===== sv/rrwa_div.sv =====
`default_nettype none

module rrwa_div (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_vld,
	input  wire rrwa_pkg::item_t               in_item,
	input  wire logic [rrwa_pkg::LEN_BITS-1:0] wave_length,
	output logic                               out_vld,
	output rrwa_pkg::item_t                    out_item,
	output logic [rrwa_pkg::PHASE_BITS-1:0]    out_phase
);
	import rrwa_pkg::*;

	typedef struct packed {
		logic [LEN_BITS-1:0]   rem;
		logic [DIV_W-1:0]      dvd;
		logic [PHASE_BITS-1:0] quo;
	} div_work_t;

	function automatic div_work_t div_step(div_work_t w, logic [LEN_BITS-1:0] d);
		div_work_t r;
		logic [LEN_BITS:0] part;
		r = w;
		for (int j = 0; j < DIV_STEPS; j++) begin
			part  = {r.rem, r.dvd[DIV_W-1]};
			r.dvd = {r.dvd[DIV_W-2:0], 1'b0};
			if (part >= {1'b0, d}) begin
				part  = part - {1'b0, d};
				r.quo = {r.quo[PHASE_BITS-2:0], 1'b1};
			end else begin
				r.quo = {r.quo[PHASE_BITS-2:0], 1'b0};
			end
			r.rem = part[LEN_BITS-1:0];
		end
		return r;
	endfunction

	logic [LEN_BITS-1:0] len_eff;
	div_work_t           work_init;
	logic                vld_s  [DIV_STAGES];
	div_work_t           work_s [DIV_STAGES];
	item_t               item_s [DIV_STAGES];

	// zero wave length acts as one
	assign len_eff = (wave_length == '0) ? LEN_BITS'(1) : wave_length;

	always_comb begin
		work_init.rem = '0;
		work_init.dvd = DIV_W'(in_item.ring_index) << DIV_SHIFT;
		work_init.quo = '0;
	end

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
		if (k == 0) begin : g_first
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[k] <= 1'b0;
				end else begin
					vld_s[k] <= in_vld;
				end
			end
			always_ff @(posedge clk) begin
				work_s[k] <= div_step(work_init, len_eff);
				item_s[k] <= in_item;
			end
		end else begin : g_next
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					vld_s[k] <= 1'b0;
				end else begin
					vld_s[k] <= vld_s[k-1];
				end
			end
			always_ff @(posedge clk) begin
				work_s[k] <= div_step(work_s[k-1], len_eff);
				item_s[k] <= item_s[k-1];
			end
		end
	end

	assign out_vld   = vld_s[DIV_STAGES-1];
	assign out_item  = item_s[DIV_STAGES-1];
	assign out_phase = work_s[DIV_STAGES-1].quo;

endmodule

`default_nettype wire

// ===== sv/rrwa_trig.sv =====
`default_nettype none

module rrwa_trig (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_vld,
	input  wire logic [rrwa_pkg::PHASE_BITS-1:0]     ring_phase,
	input  wire logic [rrwa_pkg::ANGLE_BITS-1:0]     angle_code,
	input  wire logic [rrwa_pkg::RAD_BITS-1:0]       rad,
	output logic                                     out_vld,
	output logic [rrwa_pkg::RAD_BITS-1:0]            out_rad,
	output logic signed [rrwa_pkg::TRIG_BITS-1:0]    sin_ring,
	output logic signed [rrwa_pkg::TRIG_BITS-1:0]    sin_ang,
	output logic signed [rrwa_pkg::TRIG_BITS-1:0]    cos_ang
);
	import rrwa_pkg::*;

	localparam int LANES = 3;

	logic [PHASE_BITS-1:0]       ph    [LANES];
	logic signed [TRIG_BITS-1:0] val   [LANES];
	logic                        vld_s [TRIG_LAT];
	logic [RAD_BITS-1:0]         rad_s [TRIG_LAT];

	assign ph[0] = ring_phase;
	assign ph[1] = {angle_code, (PHASE_BITS-ANGLE_BITS)'(0)};
	// cosine is the sine a quarter turn ahead
	assign ph[2] = ph[1] + 32'h4000_0000;

	for (genvar l = 0; l < LANES; l++) begin : g_lane
		logic signed [31:0]          t_s1, t_s2, t_s3, t_s4, t_s5, t_s6;
		logic signed [31:0]          t2_s2, t2_s3, t2_s4, t2_s5;
		logic signed [31:0]          acc_s3, acc_s4, acc_s5, acc_s6, m_s7;
		logic                        neg_s1, neg_s2, neg_s3, neg_s4, neg_s5, neg_s6, neg_s7;
		logic signed [TRIG_BITS-1:0] val_s8;
		logic signed [31:0]          t_in;
		logic signed [47:0]          m_ext, q;
		logic signed [TRIG_BITS-1:0] mag;

		// fold into the first quadrant
		assign t_in = ph[l][30] ? (Q30_ONE - $signed({2'b00, ph[l][29:0]}))
			: $signed({2'b00, ph[l][29:0]});

		always_comb begin
			m_ext = m_s7;
			q     = trunc_q15(m_ext);
			if (q < 0) begin
				mag = '0;
			end else if (q > TRIG_ONE) begin
				mag = TRIG_ONE[TRIG_BITS-1:0];
			end else begin
				mag = q[TRIG_BITS-1:0];
			end
		end

		always_ff @(posedge clk) begin
			t_s1   <= t_in;
			neg_s1 <= ph[l][31];
			t2_s2  <= mul_q30(t_s1, t_s1);
			t_s2   <= t_s1;
			neg_s2 <= neg_s1;
			acc_s3 <= C7 + mul_q30(C9, t2_s2);
			t2_s3  <= t2_s2;
			t_s3   <= t_s2;
			neg_s3 <= neg_s2;
			acc_s4 <= C5 + mul_q30(acc_s3, t2_s3);
			t2_s4  <= t2_s3;
			t_s4   <= t_s3;
			neg_s4 <= neg_s3;
			acc_s5 <= C3 + mul_q30(acc_s4, t2_s4);
			t2_s5  <= t2_s4;
			t_s5   <= t_s4;
			neg_s5 <= neg_s4;
			acc_s6 <= C1 + mul_q30(acc_s5, t2_s5);
			t_s6   <= t_s5;
			neg_s6 <= neg_s5;
			m_s7   <= mul_q30(acc_s6, t_s6);
			neg_s7 <= neg_s6;
			val_s8 <= neg_s7 ? -mag : mag;
		end

		assign val[l] = val_s8;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < TRIG_LAT; k++) begin
				vld_s[k] <= 1'b0;
			end
		end else begin
			vld_s[0] <= in_vld;
			for (int k = 1; k < TRIG_LAT; k++) begin
				vld_s[k] <= vld_s[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		rad_s[0] <= rad;
		for (int k = 1; k < TRIG_LAT; k++) begin
			rad_s[k] <= rad_s[k-1];
		end
	end

	assign out_vld  = vld_s[TRIG_LAT-1];
	assign out_rad  = rad_s[TRIG_LAT-1];
	assign sin_ring = val[0];
	assign sin_ang  = val[1];
	assign cos_ang  = val[2];

endmodule

`default_nettype wire

// ===== sv/rrwa_warp.sv =====
`default_nettype none

module rrwa_warp (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                in_vld,
	input  wire logic [rrwa_pkg::RAD_BITS-1:0]       rad,
	input  wire logic signed [rrwa_pkg::TRIG_BITS-1:0] sin_ring,
	input  wire logic signed [rrwa_pkg::TRIG_BITS-1:0] sin_ang,
	input  wire logic signed [rrwa_pkg::TRIG_BITS-1:0] cos_ang,
	input  wire rrwa_pkg::cfg_t                      cfg,
	output logic                                     out_vld,
	output rrwa_pkg::result_t                        result
);
	import rrwa_pkg::*;

	localparam logic [POS_BITS-1:0] LIM = POS_BITS'(1) << COORD_BITS;

	function automatic logic signed [POS_BITS-1:0] place(logic [CTR_BITS-1:0] ctr,
		logic signed [SRAD_BITS-1:0] r, logic signed [TRIG_BITS-1:0] tr);
		logic signed [47:0]         p;
		logic signed [47:0]         q;
		logic signed [POS_BITS-1:0] cs;
		logic signed [POS_BITS-1:0] qs;
		p  = r * tr;
		q  = trunc_q15(p);
		cs = {(POS_BITS-CTR_BITS)'(0), ctr};
		qs = q[POS_BITS-1:0];
		return cs + qs;
	endfunction

	function automatic logic in_frame(logic signed [POS_BITS-1:0] x,
		logic signed [POS_BITS-1:0] y, logic [POS_BITS-1:0] w, logic [POS_BITS-1:0] h);
		return !x[POS_BITS-1] && !y[POS_BITS-1]
			&& (POS_BITS'(x) < w) && (POS_BITS'(y) < h);
	endfunction

	logic                        vld_s1, vld_s2, vld_s3, vld_s4;
	logic signed [OFF_BITS-1:0]  off_s1;
	logic [RAD_BITS-1:0]         rad_s1, rad_s2;
	logic signed [TRIG_BITS-1:0] s_s1, c_s1, s_s2, c_s2;
	logic signed [SRAD_BITS-1:0] srad_s2;
	logic signed [POS_BITS-1:0]  sx_s3, sy_s3, dx_s3, dy_s3;
	result_t                     res_s4;

	logic signed [47:0]          amp_prod, amp_q;
	logic signed [SRAD_BITS-1:0] off_ext, rad_ext, drad;
	logic [POS_BITS-1:0]         w_lim, h_lim, w_ext, h_ext;
	logic                        sok, dok;
	result_t                     res_nxt;

	always_comb begin
		amp_prod = $signed({1'b0, cfg.amplitude}) * sin_ring;
		amp_q    = trunc_q15(amp_prod);
	end

	assign off_ext = off_s1;
	assign rad_ext = $signed({(SRAD_BITS-RAD_BITS)'(0), rad_s1});
	assign drad    = $signed({(SRAD_BITS-RAD_BITS)'(0), rad_s2});

	// clip the frame to the coordinate range
	assign w_ext = POS_BITS'(cfg.screen_width);
	assign h_ext = POS_BITS'(cfg.screen_height);
	assign w_lim = (w_ext < LIM) ? w_ext : LIM;
	assign h_lim = (h_ext < LIM) ? h_ext : LIM;

	always_comb begin
		sok = in_frame(sx_s3, sy_s3, w_lim, h_lim);
		dok = sok && in_frame(dx_s3, dy_s3, w_lim, h_lim);
		res_nxt.src_x  = sok ? sx_s3[COORD_BITS-1:0] : '0;
		res_nxt.src_y  = sok ? sy_s3[COORD_BITS-1:0] : '0;
		res_nxt.src_ok = sok;
		res_nxt.dst_x  = dok ? dx_s3[COORD_BITS-1:0] : '0;
		res_nxt.dst_y  = dok ? dy_s3[COORD_BITS-1:0] : '0;
		res_nxt.dst_ok = dok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		off_s1  <= amp_q[OFF_BITS-1:0];
		rad_s1  <= rad;
		s_s1    <= sin_ang;
		c_s1    <= cos_ang;
		srad_s2 <= rad_ext - off_ext;
		rad_s2  <= rad_s1;
		s_s2    <= s_s1;
		c_s2    <= c_s1;
		sx_s3   <= place(cfg.center_x, srad_s2, c_s2);
		sy_s3   <= place(cfg.center_y, srad_s2, s_s2);
		dx_s3   <= place(cfg.center_x, drad, c_s2);
		dy_s3   <= place(cfg.center_y, drad, s_s2);
		res_s4  <= res_nxt;
	end

	assign out_vld = vld_s4;
	assign result  = res_s4;

endmodule

`default_nettype wire

// ===== sv/radial_ripple_warp_address.sv =====
`default_nettype none
`include "assert_macros.svh"

// Radial ripple warp address generator.
//
// Each transaction names one sample point of a ripple ring: base radius, ring
// index and angle code. The block returns the source pixel to read and the
// destination pixel to write, each with an in-screen flag (coordinates are
// zero when the flag is clear; dst_ok needs src_ok).
//
// Input: a transaction is taken at every rising edge with start high; busy
// stays low, so a new point can follow in every cycle.
// Output: done pulses for one cycle with result; the receiver cannot hold it.
// Throughput is one point per cycle. The depth of the pipeline comes from
// the ring phase divider (four quotient bits a stage), the sine polynomial
// (at most one multiply a stage in each lane) and the offset and coordinate
// multiplies.
// Configuration: write wr_data to register wr_index while wr_en is high;
// write only while no point is in flight.
// Reset clears the pipeline valid bits and loads the register defaults.
module radial_ripple_warp_address (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	output logic                                 busy,
	input  wire rrwa_pkg::item_t                 item,
	input  wire logic                            wr_en,
	input  wire logic [rrwa_pkg::IDX_BITS-1:0]   wr_index,
	input  wire logic [rrwa_pkg::WDATA_BITS-1:0] wr_data,
	output logic                                 done,
	output rrwa_pkg::result_t                    result
);
	import rrwa_pkg::*;

	logic [CTR_BITS-1:0] center_x_q, center_y_q;
	logic [AMP_BITS-1:0] amplitude_q;
	logic [LEN_BITS-1:0] wave_length_q;
	logic [SCR_BITS-1:0] screen_width_q, screen_height_q;
	cfg_t                cfg;

	logic                        vld_s0;
	item_t                       item_s0;
	logic                        div_vld;
	item_t                       div_item;
	logic [PHASE_BITS-1:0]       div_phase;
	logic [RAD_BITS-1:0]         div_rad;
	logic                        trig_vld;
	logic [RAD_BITS-1:0]         trig_rad;
	logic signed [TRIG_BITS-1:0] sin_ring, sin_ang, cos_ang;

	// the pipeline never stalls
	assign busy = 1'b0;

	// configuration registers; truncate the write data to each register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q      <= '0;
			center_y_q      <= '0;
			amplitude_q     <= '0;
			wave_length_q   <= LEN_BITS'(1);
			screen_width_q  <= RST_SCREEN_WIDTH;
			screen_height_q <= RST_SCREEN_HEIGHT;
		end else if (wr_en) begin
			case (wr_index)
				REG_CENTER_X:      center_x_q      <= wr_data[CTR_BITS-1:0];
				REG_CENTER_Y:      center_y_q      <= wr_data[CTR_BITS-1:0];
				REG_AMPLITUDE:     amplitude_q     <= wr_data[AMP_BITS-1:0];
				REG_WAVE_LENGTH:   wave_length_q   <= wr_data[LEN_BITS-1:0];
				REG_SCREEN_WIDTH:  screen_width_q  <= wr_data[SCR_BITS-1:0];
				REG_SCREEN_HEIGHT: screen_height_q <= wr_data[SCR_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		cfg.center_x      = center_x_q;
		cfg.center_y      = center_y_q;
		cfg.amplitude     = amplitude_q;
		cfg.wave_length   = wave_length_q;
		cfg.screen_width  = screen_width_q;
		cfg.screen_height = screen_height_q;
	end

	// capture the incoming transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s0 <= 1'b0;
		end else begin
			vld_s0 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		item_s0 <= item;
	end

	// ring phase = ring * 2^31 / wave_length, low 32 bits
	rrwa_div u_div (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_vld      (vld_s0),
		.in_item     (item_s0),
		.wave_length (wave_length_q),
		.out_vld     (div_vld),
		.out_item    (div_item),
		.out_phase   (div_phase)
	);

	// ring radius; fits without overflow
	assign div_rad = RAD_BITS'(div_item.base_radius) + RAD_BITS'(div_item.ring_index);

	// ring sine, angle sine and angle cosine in parallel lanes
	rrwa_trig u_trig (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_vld     (div_vld),
		.ring_phase (div_phase),
		.angle_code (div_item.angle_code),
		.rad        (div_rad),
		.out_vld    (trig_vld),
		.out_rad    (trig_rad),
		.sin_ring   (sin_ring),
		.sin_ang    (sin_ang),
		.cos_ang    (cos_ang)
	);

	// offset, source radius, coordinates and bounds
	rrwa_warp u_warp (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (trig_vld),
		.rad      (trig_rad),
		.sin_ring (sin_ring),
		.sin_ang  (sin_ang),
		.cos_ang  (cos_ang),
		.cfg      (cfg),
		.out_vld  (done),
		.result   (result)
	);

	`RRWA_ASSERT(a_done_from_start, clk, arst_n, (done |-> $past(start && !busy, TOTAL_LAT)), "done without a matching transaction")
	`RRWA_NEVER(a_dst_needs_src, clk, arst_n, (done && result.dst_ok && !result.src_ok), "dst_ok set without src_ok")
	`RRWA_NEVER(a_src_zero, clk, arst_n, (done && !result.src_ok && (result.src_x != '0 || result.src_y != '0)), "invalid source not zeroed")

endmodule

`default_nettype wire
